>>> sv/cvm_pkg.sv
`timescale 1ns / 1ps

package cvm_pkg;

    localparam int MvW    = 16;
    localparam int SumW   = 20;
    localparam int IdxW   = 4;
    localparam int CountW = 5;

    localparam logic [MvW-1:0] UvLimitReset = 16'd2500;
    localparam logic [MvW-1:0] OvLimitReset = 16'd4200;

    // configuration register indexes
    localparam logic CfgUvLimit = 1'b0;
    localparam logic CfgOvLimit = 1'b1;

    typedef enum logic [1:0] {
        FaultOk      = 2'd0,
        FaultInvalid = 2'd1,
        FaultUv      = 2'd2,
        FaultOv      = 2'd3
    } t_fault;

    typedef struct packed {
        logic [MvW-1:0] cell_mv;
        logic           last_cell;
        logic           acquisition_failed;
    } t_cell_in;

    typedef struct packed {
        logic            data_valid;
        logic [SumW-1:0] pack_mv;
        logic [MvW-1:0]  min_mv;
        logic [IdxW-1:0] min_cell;
        logic [MvW-1:0]  max_mv;
        logic [IdxW-1:0] max_cell;
        logic [MvW-1:0]  spread_mv;
        t_fault          fault_code;
        logic [IdxW-1:0] fault_cell;
        logic            fault_active;
    } t_cell_result;

    typedef struct packed {
        logic [MvW-1:0] uv_mv;
        logic [MvW-1:0] ov_mv;
    } t_limits;

    // what the accumulator tells the pipeline control about the word it holds
    typedef struct packed {
        logic ends_set;
    } t_accum_status;

endpackage

>>> sv/cvm_accum.sv
`timescale 1ns / 1ps

module cvm_accum #(
    parameter int CELL_COUNT = 7
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_advance,
    input  cvm_pkg::t_cell_in        i_word,
    input  cvm_pkg::t_limits         i_limits,
    output cvm_pkg::t_accum_status   o_status,
    output cvm_pkg::t_cell_result    o_result
);

    localparam logic [cvm_pkg::CountW-1:0] CountFull = cvm_pkg::CountW'(CELL_COUNT);
    localparam logic [cvm_pkg::CountW-1:0] CountOver = cvm_pkg::CountW'(CELL_COUNT + 1);

    logic [cvm_pkg::SumW-1:0]   r_sum,     n_sum;
    logic [cvm_pkg::MvW-1:0]    r_min,     n_min;
    logic [cvm_pkg::IdxW-1:0]   r_min_idx, n_min_idx;
    logic [cvm_pkg::MvW-1:0]    r_max,     n_max;
    logic [cvm_pkg::IdxW-1:0]   r_max_idx, n_max_idx;
    logic [cvm_pkg::CountW-1:0] r_cnt,     n_cnt;
    cvm_pkg::t_fault            r_fault,   n_fault;
    logic [cvm_pkg::IdxW-1:0]   r_flt_idx, n_flt_idx;

    logic [cvm_pkg::IdxW-1:0] idx;
    logic                     ends_set;

    assign idx      = r_cnt[cvm_pkg::IdxW-1:0];
    assign ends_set = i_word.acquisition_failed | i_word.last_cell;

    // running statistics with this word folded in
    always_comb begin
        n_sum     = r_sum;
        n_min     = r_min;
        n_min_idx = r_min_idx;
        n_max     = r_max;
        n_max_idx = r_max_idx;
        n_cnt     = r_cnt;
        n_fault   = r_fault;
        n_flt_idx = r_flt_idx;
        if (r_cnt < CountFull) begin
            n_sum = r_sum + cvm_pkg::SumW'(i_word.cell_mv);
            if (r_cnt == '0) begin
                n_min     = i_word.cell_mv;
                n_min_idx = idx;
                n_max     = i_word.cell_mv;
                n_max_idx = idx;
            end else begin
                if (i_word.cell_mv < r_min) begin
                    n_min     = i_word.cell_mv;
                    n_min_idx = idx;
                end
                if (i_word.cell_mv > r_max) begin
                    n_max     = i_word.cell_mv;
                    n_max_idx = idx;
                end
            end
            if (r_fault == cvm_pkg::FaultOk) begin
                if (i_word.cell_mv < i_limits.uv_mv) begin
                    n_fault   = cvm_pkg::FaultUv;
                    n_flt_idx = idx;
                end else if (i_word.cell_mv > i_limits.ov_mv) begin
                    n_fault   = cvm_pkg::FaultOv;
                    n_flt_idx = idx;
                end
            end
            n_cnt = r_cnt + 1'b1;
        end else begin
            n_cnt = CountOver;
        end
    end

    always_comb begin
        o_status.ends_set = ends_set;
        o_result          = '0;
        if (i_word.acquisition_failed || (n_cnt != CountFull)) begin
            o_result.fault_code   = cvm_pkg::FaultInvalid;
            o_result.fault_active = 1'b1;
        end else begin
            o_result.data_valid   = 1'b1;
            o_result.pack_mv      = n_sum;
            o_result.min_mv       = n_min;
            o_result.min_cell     = n_min_idx;
            o_result.max_mv       = n_max;
            o_result.max_cell     = n_max_idx;
            o_result.spread_mv    = n_max - n_min;
            o_result.fault_code   = n_fault;
            o_result.fault_cell   = n_flt_idx;
            o_result.fault_active = (n_fault != cvm_pkg::FaultOk);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_advance && ends_set)) begin
            r_sum     <= '0;
            r_min     <= '0;
            r_min_idx <= '0;
            r_max     <= '0;
            r_max_idx <= '0;
            r_cnt     <= '0;
            r_fault   <= cvm_pkg::FaultOk;
            r_flt_idx <= '0;
        end else if (i_advance) begin
            r_sum     <= n_sum;
            r_min     <= n_min;
            r_min_idx <= n_min_idx;
            r_max     <= n_max;
            r_max_idx <= n_max_idx;
            r_cnt     <= n_cnt;
            r_fault   <= n_fault;
            r_flt_idx <= n_flt_idx;
        end
    end

endmodule

>>> sv/cvm_out_reg.sv
`timescale 1ns / 1ps

module cvm_out_reg (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_load,
    input  cvm_pkg::t_cell_result i_word,
    input  logic                  i_ready,
    output logic                  o_valid,
    output cvm_pkg::t_cell_result o_word
);

    logic                  r_valid;
    cvm_pkg::t_cell_result r_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_word <= i_word;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

>>> sv/cell_voltage_monitor.sv
`timescale 1ns / 1ps

// Channel  Direction  Handshake                  Word
// in       input      i_in_valid / o_in_ready    t_cell_in: one cell reading
// out      output     o_out_valid / i_out_ready  t_cell_result: one per set
// cfg      input      i_cfg_valid / o_cfg_ready  index + 16-bit limit
//
// One word per cycle sustained unless a set-ending word waits on the result.
// A reading lands in the input register, is folded into the running set
// state as it advances; a set-ending word also loads the result register then.
// Reset (synchronous, active low) clears the set state and both valids and
// loads the limits with 2500 mV / 4200 mV.
// A stalled result holds only set-ending words; other readings keep flowing.

module cell_voltage_monitor #(
    parameter int CELL_COUNT = 7
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  cvm_pkg::t_cell_in     i_in_word,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output cvm_pkg::t_cell_result o_out_word,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic                  i_cfg_index,
    input  logic [15:0]           i_cfg_data
);

    // limit registers
    cvm_pkg::t_limits r_limits;

    // input register
    logic              r_in_valid;
    cvm_pkg::t_cell_in r_in_word;

    logic                   advance;
    cvm_pkg::t_accum_status status;
    cvm_pkg::t_cell_result  result;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limits.uv_mv <= cvm_pkg::UvLimitReset;
            r_limits.ov_mv <= cvm_pkg::OvLimitReset;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                cvm_pkg::CfgUvLimit: r_limits.uv_mv <= i_cfg_data;
                cvm_pkg::CfgOvLimit: r_limits.ov_mv <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // The held word moves on unless it ends a set and the result slot is
    // still occupied by an untaken result.
    assign advance    = r_in_valid && (!status.ends_set || !o_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_word <= i_in_word;
        end
    end

    cvm_accum #(
        .CELL_COUNT (CELL_COUNT)
    ) u_accum (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_word    (r_in_word),
        .i_limits  (r_limits),
        .o_status  (status),
        .o_result  (result)
    );

    cvm_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (advance && status.ends_set),
        .i_word  (result),
        .i_ready (i_out_ready),
        .o_valid (o_out_valid),
        .o_word  (o_out_word)
    );

endmodule

>>> sv/cvm_checker.sv
`timescale 1ns / 1ps

module cvm_checker (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_out_valid,
    input logic                  i_out_ready,
    input cvm_pkg::t_cell_result o_out_word
);

    // a result waits until taken, unchanged
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_word))
        else $error("result dropped or changed while stalled");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_fault_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_word.fault_active == (o_out_word.fault_code != cvm_pkg::FaultOk))
        else $error("fault_active disagrees with fault_code");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_word.data_valid |->
            o_out_word.fault_code == cvm_pkg::FaultInvalid && o_out_word.pack_mv == '0 &&
            o_out_word.min_mv == '0 && o_out_word.max_mv == '0 &&
            o_out_word.fault_cell == '0)
        else $error("invalid set carries data");

    a_spread: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.data_valid |->
            o_out_word.min_mv <= o_out_word.max_mv &&
            o_out_word.spread_mv == o_out_word.max_mv - o_out_word.min_mv &&
            o_out_word.fault_code != cvm_pkg::FaultInvalid)
        else $error("min/max/spread inconsistent");

endmodule

bind cell_voltage_monitor cvm_checker u_cvm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_word  (o_out_word)
);
